/* rtl/core/lzsd_pkg.sv */
// Shared types and constants of the LZSS stream decompressor.
`timescale 1ns / 1ps

package lzsd_pkg;

    localparam int HIST_DEPTH = 4096;
    localparam int HDR_BYTES  = 8;
    localparam int LEN_BITS   = 4;
    localparam int DIST_BITS  = 12;
    localparam int CNT_W      = LEN_BITS + 1;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_CMD    = 3'd1,
        PH_ELEM   = 3'd2,
        PH_DIST2  = 3'd3,
        PH_DRAIN  = 3'd4
    } t_phase;

    typedef enum logic {
        ENG_IDLE = 1'b0,
        ENG_COPY = 1'b1
    } t_eng;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_OK    = 2'd1,
        ST_BAD   = 2'd2,
        ST_SMALL = 2'd3
    } t_status;

    typedef enum logic {
        CFG_MAGIC    = 1'b0,
        CFG_CAPACITY = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        t_status    status;
    } t_out_item;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [31:0] output_capacity;
    } t_cfg;

    // decoder to output stage
    typedef struct packed {
        logic      in_ready;
        logic      copy_busy;
        logic      emit;
        t_out_item item;
    } t_ctrl_out;

endpackage

/* rtl/core/lzss_stream_decompressor.sv */
// Top level: configuration registers, output register and decoder.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+------------------------------
//  in      | in  | i_in_valid / o_in_ready   | i_in  (lzsd_pkg::t_in_item)
//  out     | out | o_out_valid / i_out_ready | o_out (lzsd_pkg::t_out_item)
//  cfg     | in  | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
// Header, command and literal bytes are handled as they are accepted. A match
// is accepted and then copies 2..16 bytes, each with one read and one write on
// the history RAM; no new request is taken until the copy is done.
// Synchronous reset clears control state; history stays undefined, no sweep.
// Back-pressure on the output holds the copy engine; a request is taken in
// only when the engine is idle and the output register is free.
`timescale 1ns / 1ps

module lzss_stream_decompressor #(
    parameter int HIST_DEPTH = lzsd_pkg::HIST_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lzsd_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lzsd_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);

    lzsd_pkg::t_cfg      r_cfg;
    logic                r_out_valid;
    lzsd_pkg::t_out_item r_out;
    lzsd_pkg::t_ctrl_out ctrl;
    logic                out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_word      <= 32'd0;
            r_cfg.output_capacity <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            unique case (lzsd_pkg::t_cfg_idx'(i_cfg_idx))
                lzsd_pkg::CFG_MAGIC:    r_cfg.magic_word      <= i_cfg_data;
                lzsd_pkg::CFG_CAPACITY: r_cfg.output_capacity <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lzsd_ctrl #(
        .HIST_DEPTH (HIST_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_out <= ctrl.item;
        end
    end

    assign o_in_ready  = ctrl.in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.emit |-> out_free)
        else $error("result produced while output register still full");

    a_no_accept_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> !ctrl.copy_busy)
        else $error("request taken during a match copy");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != lzsd_pkg::ST_BUSY) |-> o_out.run_last)
        else $error("status on a result that is not the last");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.byte_valid) |->
            (o_out.run_last && o_out.status != lzsd_pkg::ST_BUSY))
        else $error("empty result without a final status");

endmodule

/* rtl/core/lzsd_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module lzsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/lzsd_ctrl.sv */
// Packet parser and match copy engine around the history RAM.
`timescale 1ns / 1ps

module lzsd_ctrl #(
    parameter int HIST_DEPTH = lzsd_pkg::HIST_DEPTH,
    localparam int AW        = $clog2(HIST_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lzsd_pkg::t_cfg      i_cfg,
    input  logic                i_in_valid,
    input  lzsd_pkg::t_in_item  i_in,
    input  logic                i_out_free,
    output lzsd_pkg::t_ctrl_out o_ctrl
);

    lzsd_pkg::t_phase r_phase, n_phase;
    lzsd_pkg::t_eng   r_eng, n_eng;
    logic [AW-1:0]    r_wp, n_wp;
    logic [2:0]       r_hcount, n_hcount;
    logic [63:0]      r_hshift, n_hshift;
    logic [31:0]      r_exp, n_exp;
    logic [31:0]      r_total, n_total;
    logic [7:0]       r_cmd, n_cmd;
    logic [2:0]       r_bit, n_bit;
    logic [7:0]       r_dh, n_dh;
    logic [AW-1:0]    r_rd, n_rd;
    logic [lzsd_pkg::CNT_W-1:0] r_rem, n_rem;
    logic             r_copy_last, n_copy_last;
    logic             r_fwd_hit;
    logic [7:0]       r_fwd_data;

    logic             ram_we, ram_re;
    logic [7:0]       ram_wdata, ram_q, hist_q;
    logic [AW-1:0]    ram_raddr;

    logic             in_ready, accept, last;
    logic [7:0]       b;
    lzsd_pkg::t_status st;
    logic             emit;
    lzsd_pkg::t_out_item item;

    logic [lzsd_pkg::DIST_BITS-1:0] back_dist;
    logic [lzsd_pkg::CNT_W-1:0]     count;
    logic [32:0]      sum_lit, sum_copy, dist_need;

    lzsd_ram #(
        .WIDTH (8),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // read that hits the entry written in the same cycle takes the new byte
    assign hist_q = r_fwd_hit ? r_fwd_data : ram_q;

    assign in_ready = (r_eng == lzsd_pkg::ENG_IDLE) && i_out_free;
    assign accept   = i_in_valid && in_ready;
    assign b        = i_in.in_byte;
    assign last     = i_in.in_last;

    assign back_dist = {r_dh, b[7:lzsd_pkg::LEN_BITS]};
    assign count     = {1'b0, b[lzsd_pkg::LEN_BITS-1:0]} + lzsd_pkg::CNT_W'(1);
    assign sum_lit   = {1'b0, r_total} + 33'd1;
    assign sum_copy  = {1'b0, r_total} + 33'(count);
    assign dist_need = 33'(back_dist) + 33'd1;

    always_comb begin
        n_phase     = r_phase;
        n_eng       = r_eng;
        n_wp        = r_wp;
        n_hcount    = r_hcount;
        n_hshift    = r_hshift;
        n_exp       = r_exp;
        n_total     = r_total;
        n_cmd       = r_cmd;
        n_bit       = r_bit;
        n_dh        = r_dh;
        n_rd        = r_rd;
        n_rem       = r_rem;
        n_copy_last = r_copy_last;
        ram_we      = 1'b0;
        ram_wdata   = b;
        ram_re      = 1'b0;
        ram_raddr   = r_rd;
        st          = lzsd_pkg::ST_BUSY;
        emit        = 1'b0;
        item        = '0;

        if (r_eng == lzsd_pkg::ENG_COPY) begin
            if (i_out_free) begin
                emit            = 1'b1;
                item.out_byte   = hist_q;
                item.byte_valid = 1'b1;
                ram_we          = 1'b1;
                ram_wdata       = hist_q;
                n_wp            = r_wp + AW'(1);
                n_rem           = r_rem - lzsd_pkg::CNT_W'(1);
                if (r_rem == lzsd_pkg::CNT_W'(1)) begin
                    item.run_last = 1'b1;
                    item.status   = r_copy_last ? lzsd_pkg::ST_BAD : lzsd_pkg::ST_BUSY;
                    n_eng         = lzsd_pkg::ENG_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_rd + AW'(1);
                    n_rd      = r_rd + AW'(1);
                end
            end
        end else if (accept) begin
            unique case (r_phase)
                lzsd_pkg::PH_HEADER: begin
                    n_hshift = {b, r_hshift[63:8]};
                    if (r_hcount == 3'(lzsd_pkg::HDR_BYTES - 1)) begin
                        n_hcount = '0;
                        if (last || n_hshift[31:0] != i_cfg.magic_word ||
                            n_hshift[63:32] == 32'd0) begin
                            st = lzsd_pkg::ST_BAD;
                        end else if (n_hshift[63:32] > i_cfg.output_capacity) begin
                            st = lzsd_pkg::ST_SMALL;
                        end else begin
                            n_exp   = n_hshift[63:32];
                            n_total = '0;
                            n_bit   = '0;
                            n_cmd   = '0;
                            n_phase = lzsd_pkg::PH_CMD;
                        end
                    end else begin
                        n_hcount = r_hcount + 3'd1;
                        if (last) st = lzsd_pkg::ST_BAD;
                    end
                end
                lzsd_pkg::PH_CMD: begin
                    n_cmd   = b;
                    n_bit   = '0;
                    n_phase = lzsd_pkg::PH_ELEM;
                    if (last) st = lzsd_pkg::ST_BAD;
                end
                lzsd_pkg::PH_ELEM: begin
                    if (r_cmd[0]) begin
                        n_dh    = b;
                        n_phase = lzsd_pkg::PH_DIST2;
                        if (last) st = lzsd_pkg::ST_BAD;
                    end else if (sum_lit > {1'b0, i_cfg.output_capacity}) begin
                        st = lzsd_pkg::ST_BAD;
                    end else begin
                        emit            = 1'b1;
                        item.out_byte   = b;
                        item.byte_valid = 1'b1;
                        ram_we          = 1'b1;
                        n_wp            = r_wp + AW'(1);
                        n_total         = sum_lit[31:0];
                        n_cmd           = {1'b0, r_cmd[7:1]};
                        n_bit           = r_bit + 3'd1;
                        n_phase = (r_bit == 3'd7) ? lzsd_pkg::PH_CMD : lzsd_pkg::PH_ELEM;
                        if (last) st = lzsd_pkg::ST_BAD;
                    end
                end
                lzsd_pkg::PH_DIST2: begin
                    if (b[lzsd_pkg::LEN_BITS-1:0] == '0) begin
                        // end code
                        st = (r_total == r_exp) ? lzsd_pkg::ST_OK : lzsd_pkg::ST_BAD;
                    end else if (sum_copy > {1'b0, i_cfg.output_capacity} ||
                                 dist_need > {1'b0, r_total}) begin
                        st = lzsd_pkg::ST_BAD;
                    end else begin
                        ram_re      = 1'b1;
                        ram_raddr   = r_wp - AW'(back_dist) - AW'(1);
                        n_rd        = ram_raddr;
                        n_rem       = count;
                        n_copy_last = last;
                        n_eng       = lzsd_pkg::ENG_COPY;
                        n_total     = sum_copy[31:0];
                        n_cmd       = {1'b0, r_cmd[7:1]};
                        n_bit       = r_bit + 3'd1;
                        n_phase = (r_bit == 3'd7) ? lzsd_pkg::PH_CMD : lzsd_pkg::PH_ELEM;
                        // a source that ends here is flagged on the final copied byte
                        if (last) begin
                            n_phase  = lzsd_pkg::PH_HEADER;
                            n_hcount = '0;
                        end
                    end
                end
                lzsd_pkg::PH_DRAIN: begin
                    if (last) begin
                        n_phase  = lzsd_pkg::PH_HEADER;
                        n_hcount = '0;
                    end
                end
                default: begin
                    n_phase = lzsd_pkg::PH_HEADER;
                end
            endcase

            if (st != lzsd_pkg::ST_BUSY) begin
                n_phase  = last ? lzsd_pkg::PH_HEADER : lzsd_pkg::PH_DRAIN;
                n_hcount = '0;
                emit     = 1'b1;
            end
            if (emit) begin
                item.run_last = 1'b1;
                item.status   = st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lzsd_pkg::PH_HEADER;
            r_eng       <= lzsd_pkg::ENG_IDLE;
            r_wp        <= '0;
            r_hcount    <= '0;
            r_hshift    <= '0;
            r_exp       <= '0;
            r_total     <= '0;
            r_cmd       <= '0;
            r_bit       <= '0;
            r_dh        <= '0;
            r_copy_last <= 1'b0;
            r_fwd_hit   <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_eng       <= n_eng;
            r_wp        <= n_wp;
            r_hcount    <= n_hcount;
            r_hshift    <= n_hshift;
            r_exp       <= n_exp;
            r_total     <= n_total;
            r_cmd       <= n_cmd;
            r_bit       <= n_bit;
            r_dh        <= n_dh;
            r_copy_last <= n_copy_last;
            if (ram_re) begin
                r_fwd_hit <= ram_we && (ram_raddr == r_wp);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd  <= n_rd;
        r_rem <= n_rem;
        if (ram_re) begin
            r_fwd_data <= ram_wdata;
        end
    end

    assign o_ctrl.in_ready  = in_ready;
    assign o_ctrl.copy_busy = (r_eng == lzsd_pkg::ENG_COPY);
    assign o_ctrl.emit      = emit;
    assign o_ctrl.item      = item;

endmodule
